// ===== rtl/assert_macros.svh =====
// Assertion macros for the MD5 digest unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

// ===== rtl/md5_pkg.sv =====
// Package: MD5 constants, round tables and controller/datapath command types.
`default_nettype none
package md5_pkg;
   localparam logic [31:0] INIT_A = 32'h67452301;
   localparam logic [31:0] INIT_B = 32'hefcdab89;
   localparam logic [31:0] INIT_C = 32'h98badcfe;
   localparam logic [31:0] INIT_D = 32'h10325476;
   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [5:0] LEN_POS = 6'd56;

   typedef enum logic [1:0] {
      BSRC_DATA = 2'd0,
      BSRC_PAD  = 2'd1,
      BSRC_ZERO = 2'd2,
      BSRC_LEN  = 2'd3
   } byte_src_type;

   typedef struct packed {
      logic         write_byte;
      byte_src_type byte_src;
      logic         add_len;
      logic         latch_len;
      logic         round_start;
      logic         round_step;
      logic         round_done;
      logic         restart;
   } md5_cmd_type;

   typedef struct packed {
      logic       block_full;
      logic [5:0] fill;
      logic [5:0] round;
   } md5_status_type;

   function automatic logic [31:0] round_const(input logic [5:0] i);
      logic [31:0] k [64];
      k = '{32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf,
            32'h4787c62a, 32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af,
            32'hffff5bb1, 32'h895cd7be, 32'h6b901122, 32'hfd987193, 32'ha679438e,
            32'h49b40821, 32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
            32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8, 32'h21e1cde6,
            32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
            32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122,
            32'hfde5380c, 32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
            32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05, 32'hd9d4d039,
            32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665, 32'hf4292244, 32'h432aff97,
            32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d,
            32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
            32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
      return k[i];
   endfunction

   function automatic logic [4:0] rot_amount(input logic [5:0] i);
      logic [4:0] r [16];
      r = '{5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
            5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21};
      return r[{i[5:4], i[1:0]}];
   endfunction

   function automatic logic [3:0] word_index(input logic [5:0] i);
      logic [3:0] g;
      case (i[5:4])
         2'd0: g = i[3:0];
         2'd1: g = 4'(5 * i[3:0] + 1);
         2'd2: g = 4'(3 * i[3:0] + 5);
         default: g = 4'(7 * i[3:0]);
      endcase
      return g;
   endfunction
endpackage
`default_nettype wire

// ===== rtl/md5_message_digest_unit.sv =====
// MD5 message digest unit: top level joining controller and datapath.
// Usage:
//  Input channel req_*: one message byte per transfer. req_tdata = data_byte,
//  req_tuser = byte_valid (byte belongs to message), req_tlast ends the message.
//  Output channel rsp_*: one 128-bit digest per message, digest byte 0 in bits 7:0.
//  Flow: a byte that does not complete a 64-byte block is written and the unit
//  stays ready. A byte that completes a block starts the 64 rounds of the single
//  round unit, one per cycle. The last transfer then runs padding, one byte
//  per cycle while no block is compressed, plus 64 rounds per padded block (one
//  or two blocks), after which rsp_tvalid rises.
//  The unit works on one message at a time; req_tready is low while padding,
//  compressing or holding a digest.
//  Reset: synchronous, active high; chaining words return to the MD5 initial
//  values and the length count clears. While the receiver stalls the digest
//  holds on rsp_tdata and no new byte is taken. After the digest transfer the
//  unit returns to its initial state for the next message.
`default_nettype none
module md5_message_digest_unit (
   input  wire  logic         clock,
   input  wire  logic         reset,
   input  wire  logic         req_tvalid,
   output       logic         req_tready,
   input  wire  logic [7:0]   req_tdata,   // [7:0] data_byte
   input  wire  logic         req_tuser,   // [0] byte_valid
   input  wire  logic         req_tlast,
   output       logic         rsp_tvalid,
   input  wire  logic         rsp_tready,
   output       logic [127:0] rsp_tdata    // [63:0] digest_low, [127:64] digest_high
);
   md5_pkg::md5_cmd_type    cmd;
   md5_pkg::md5_status_type status;

   md5_controller u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .byte_valid(req_tuser), .last(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .status(status), .cmd(cmd)
   );

   md5_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .data_byte(req_tdata),
      .status(status), .digest(rsp_tdata)
   );
endmodule
`default_nettype wire

// ===== rtl/md5_datapath.sv =====
// MD5 datapath: block store, length counter, chaining words and round unit.
`default_nettype none
`include "assert_macros.svh"
module md5_datapath (
   input  wire  logic                   clock,
   input  wire  logic                   reset,
   input  wire  md5_pkg::md5_cmd_type   cmd,
   input  wire  logic [7:0]             data_byte,
   output       md5_pkg::md5_status_type status,
   output       logic [127:0]           digest
);
   logic [31:0] words_ff [16];
   logic [5:0]  fill_ff, fill_in;
   logic [5:0]  round_ff, round_in;
   logic [63:0] len_ff, len_in;
   logic [63:0] len_hold_ff;
   logic [31:0] ch_ff [4];
   logic [31:0] a_ff, b_ff, c_ff, d_ff;
   logic [7:0]  wbyte;
   logic [31:0] f, sum, rot;

   always_comb begin
      case (cmd.byte_src)
         md5_pkg::BSRC_DATA: wbyte = data_byte;
         md5_pkg::BSRC_PAD:  wbyte = md5_pkg::PAD_BYTE;
         md5_pkg::BSRC_LEN:  wbyte = len_hold_ff[{fill_ff[2:0], 3'd0} +: 8];
         default:            wbyte = 8'd0;
      endcase
   end

   assign fill_in = cmd.restart ? 6'd0 : (cmd.write_byte ? fill_ff + 6'd1 : fill_ff);
   assign len_in = cmd.restart ? 64'd0 : (cmd.add_len ? len_ff + 64'd8 : len_ff);
   assign round_in = cmd.round_start ? 6'd0 : (cmd.round_step ? round_ff + 6'd1 : round_ff);

   always_comb begin
      case (round_ff[5:4])
         2'd0: f = (b_ff & c_ff) | (~b_ff & d_ff);
         2'd1: f = (b_ff & d_ff) | (c_ff & ~d_ff);
         2'd2: f = b_ff ^ c_ff ^ d_ff;
         default: f = c_ff ^ (b_ff | ~d_ff);
      endcase
      sum = a_ff + f + md5_pkg::round_const(round_ff)
            + words_ff[md5_pkg::word_index(round_ff)];
      rot = (sum << md5_pkg::rot_amount(round_ff))
            | (sum >> (6'd32 - {1'b0, md5_pkg::rot_amount(round_ff)}));
   end

   always_ff @(posedge clock) begin
      if (cmd.write_byte)
         words_ff[fill_ff[5:2]][{fill_ff[1:0], 3'd0} +: 8] <= wbyte;
      if (cmd.latch_len)
         len_hold_ff <= len_ff;
      if (cmd.round_start) begin
         a_ff <= ch_ff[0];
         b_ff <= ch_ff[1];
         c_ff <= ch_ff[2];
         d_ff <= ch_ff[3];
      end else if (cmd.round_step) begin
         a_ff <= d_ff;
         b_ff <= b_ff + rot;
         c_ff <= b_ff;
         d_ff <= c_ff;
      end
   end

   // final round's outputs fold straight into the chaining words
   always_ff @(posedge clock) begin
      if (reset || cmd.restart) begin
         ch_ff[0] <= md5_pkg::INIT_A;
         ch_ff[1] <= md5_pkg::INIT_B;
         ch_ff[2] <= md5_pkg::INIT_C;
         ch_ff[3] <= md5_pkg::INIT_D;
      end else if (cmd.round_done) begin
         ch_ff[0] <= ch_ff[0] + d_ff;
         ch_ff[1] <= ch_ff[1] + b_ff + rot;
         ch_ff[2] <= ch_ff[2] + b_ff;
         ch_ff[3] <= ch_ff[3] + c_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= 6'd0;
         len_ff   <= 64'd0;
         round_ff <= 6'd0;
      end else begin
         fill_ff  <= fill_in;
         len_ff   <= len_in;
         round_ff <= round_in;
      end
   end

   assign status = '{block_full: (fill_ff == 6'd63), fill: fill_ff, round: round_ff};
   assign digest = {ch_ff[3], ch_ff[2], ch_ff[1], ch_ff[0]};

   `ASSERT_NEXT(a_restart_clear, clock, reset, cmd.restart, fill_ff == 6'd0 && len_ff == 64'd0)
   `ASSERT_NEXT(a_round_start, clock, reset, cmd.round_start, round_ff == 6'd0)
   `ASSERT_IMPLIES(a_done_last, clock, reset, cmd.round_done, round_ff == 6'd63)
endmodule
`default_nettype wire

// ===== rtl/md5_controller.sv =====
// MD5 controller: handshakes, padding sequence and round sequencing.
`default_nettype none
`include "assert_macros.svh"
module md5_controller (
   input  wire  logic                    clock,
   input  wire  logic                    reset,
   input  wire  logic                    req_tvalid,
   output       logic                    req_tready,
   input  wire  logic                    byte_valid,
   input  wire  logic                    last,
   output       logic                    rsp_tvalid,
   input  wire  logic                    rsp_tready,
   input  wire  md5_pkg::md5_status_type status,
   output       md5_pkg::md5_cmd_type    cmd
);
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ROUND = 3'd1;
   localparam logic [2:0] ST_PAD   = 3'd2;
   localparam logic [2:0] ST_ZERO  = 3'd3;
   localparam logic [2:0] ST_LEN   = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [2:0] ret_ff, ret_in;
   logic       accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign accept = req_tvalid && req_tready;

   always_comb begin
      cmd = '0;
      cmd.byte_src = md5_pkg::BSRC_DATA;
      state_in = state_ff;
      ret_in = ret_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.write_byte = byte_valid;
               cmd.add_len = byte_valid;
               if (byte_valid && status.block_full) begin
                  cmd.round_start = 1'b1;
                  state_in = ST_ROUND;
                  ret_in = last ? ST_PAD : ST_IDLE;
               end else if (last) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_ROUND: begin
            cmd.round_step = 1'b1;
            if (status.round == 6'd63) begin
               cmd.round_done = 1'b1;
               state_in = ret_ff;
            end
         end
         ST_PAD: begin
            cmd.write_byte = 1'b1;
            cmd.byte_src = md5_pkg::BSRC_PAD;
            cmd.latch_len = 1'b1;
            ret_in = ST_ZERO;
            if (status.fill == 6'd63) begin
               cmd.round_start = 1'b1;
               state_in = ST_ROUND;
            end else begin
               state_in = ST_ZERO;
            end
         end
         ST_ZERO: begin
            if (status.fill == md5_pkg::LEN_POS) begin
               state_in = ST_LEN;
            end else begin
               cmd.write_byte = 1'b1;
               cmd.byte_src = md5_pkg::BSRC_ZERO;
               if (status.fill == 6'd63) begin
                  cmd.round_start = 1'b1;
                  ret_in = ST_ZERO;
                  state_in = ST_ROUND;
               end
            end
         end
         ST_LEN: begin
            cmd.write_byte = 1'b1;
            cmd.byte_src = md5_pkg::BSRC_LEN;
            if (status.fill == 6'd63) begin
               cmd.round_start = 1'b1;
               ret_in = ST_OUT;
               state_in = ST_ROUND;
            end
         end
         ST_OUT: begin
            if (rsp_tready) begin
               cmd.restart = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_IDLE;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

   `ASSERT_IMPLIES(a_no_accept_busy, clock, reset, state_ff != ST_IDLE, !req_tready)
   `ASSERT_NEXT(a_out_holds, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `ASSERT_IMPLIES(a_one_cmd, clock, reset, 1'b1, !(cmd.round_start && cmd.round_step))
endmodule
`default_nettype wire
